// ===== sv/tlf_pkg.sv =====
package tlf_pkg;

   // Line store geometry.
   localparam int LINE_DEPTH = 62;
   localparam int IDX_W      = $clog2(LINE_DEPTH);
   localparam int COL_W      = $clog2(LINE_DEPTH + 1);

   // A programmed width of zero stands for this column count before saturation.
   localparam int WIDTH_WHEN_ZERO = 80;

   // Character codes.
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // Input command codes.
   localparam logic CMD_TEXT = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // Register map: the word index is taken from bit 2 of the byte address.
   localparam int         CSR_ADDR_W         = 3;
   localparam logic [0:0] REG_LINE_WIDTH     = 1'b0;
   localparam logic [0:0] REG_BREAK_AT_SPACE = 1'b1;

   typedef logic [COL_W-1:0] col_type;

   // One output word handed from the sequencer to the output register.
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
   } emit_type;

   // Access request to the line store.
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [7:0]       wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } store_req_type;

   // Effective wrap column: zero means the default, and the result never
   // exceeds the store depth.
   function automatic col_type eff_width(input logic [5:0] line_width);
      int w;
      if (line_width == 6'd0) begin
         w = WIDTH_WHEN_ZERO;
      end else begin
         w = int'(line_width);
      end
      if (w > LINE_DEPTH) begin
         w = LINE_DEPTH;
      end
      return col_type'(w);
   endfunction

endpackage

// ===== sv/tlf_line_store.sv =====
module tlf_line_store (
   input  logic                   clock,
   input  tlf_pkg::store_req_type store_req,
   output logic [7:0]             rd_data
);
   import tlf_pkg::*;

   logic [7:0] mem [LINE_DEPTH];
   logic [7:0] rd_data_ff;

   // One write port and one read port; the read data is registered.
   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[store_req.wr_addr] <= store_req.wr_data;
      end
      if (store_req.rd_en) begin
         rd_data_ff <= mem[store_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/tlf_sequencer.sv =====
module tlf_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_command,
   input  logic [7:0]             req_char,
   output logic                   req_ready,
   input  tlf_pkg::col_type       width,
   input  logic                   break_at_space,
   input  logic                   out_free,
   output tlf_pkg::emit_type      emit,
   output tlf_pkg::store_req_type store_req,
   input  logic [7:0]             rd_data
);
   import tlf_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SCAN_RD  = 4'd1;
   localparam logic [3:0] S_SCAN_CHK = 4'd2;
   localparam logic [3:0] S_EMIT_RD  = 4'd3;
   localparam logic [3:0] S_EMIT_OUT = 4'd4;
   localparam logic [3:0] S_CR       = 4'd5;
   localparam logic [3:0] S_LF       = 4'd6;
   localparam logic [3:0] S_MOVE_RD  = 4'd7;
   localparam logic [3:0] S_MOVE_WR  = 4'd8;
   localparam logic [3:0] S_WRITE    = 4'd9;
   localparam logic [3:0] S_CHAR     = 4'd10;

   logic [3:0] state_ff, state_in;
   col_type    column_ff, column_in;
   col_type    idx_ff, idx_in;
   col_type    limit_ff, limit_in;
   logic [7:0] char_ff, char_in;
   logic       move_ff, move_in;
   logic       wr_ff, wr_in;
   logic       hard_ff, hard_in;

   // The shared index unit: a decrement, an increment, one offset and two end compares.
   col_type idx_dec;
   col_type idx_inc;
   col_type idx_off;
   logic    idx_at_limit;
   logic    idx_at_column;

   assign idx_dec       = idx_ff - col_type'(1);
   assign idx_inc       = idx_ff + col_type'(1);
   assign idx_off       = idx_ff - limit_ff;
   assign idx_at_limit  = (idx_inc == limit_ff);
   assign idx_at_column = (idx_inc == column_ff);

   assign req_ready = (state_ff == S_IDLE);

   // Sequencer: decode an accepted word, then scan, emit, move and write.
   always_comb begin
      state_in  = state_ff;
      column_in = column_ff;
      idx_in    = idx_ff;
      limit_in  = limit_ff;
      char_in   = char_ff;
      move_in   = move_ff;
      wr_in     = wr_ff;
      hard_in   = hard_ff;
      emit      = '0;
      store_req = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               char_in = req_char;
               move_in = 1'b0;
               wr_in   = 1'b0;
               hard_in = 1'b0;
               idx_in  = '0;
               if (req_command == CMD_END) begin
                  if (column_ff == '0) begin
                     state_in = S_IDLE;
                  end else if (break_at_space) begin
                     limit_in = column_ff;
                     state_in = S_EMIT_RD;
                  end else begin
                     state_in = S_CR;
                  end
               end else if (req_char == CH_LF) begin
                  if (break_at_space && column_ff != '0) begin
                     limit_in = column_ff;
                     state_in = S_EMIT_RD;
                  end else begin
                     state_in = S_CR;
                  end
               end else if (req_char == CH_CR) begin
                  state_in = S_IDLE;
               end else if (break_at_space) begin
                  wr_in = 1'b1;
                  if (column_ff >= width) begin
                     idx_in   = column_ff;
                     state_in = S_SCAN_RD;
                  end else begin
                     state_in = S_WRITE;
                  end
               end else begin
                  wr_in   = 1'b1;
                  hard_in = 1'b1;
                  if (column_ff >= width) begin
                     state_in = S_CR;
                  end else begin
                     state_in = S_WRITE;
                  end
               end
            end
         end

         // Backward search for the last space in the held line.
         S_SCAN_RD: begin
            store_req.rd_en   = 1'b1;
            store_req.rd_addr = idx_dec[IDX_W-1:0];
            idx_in            = idx_dec;
            state_in          = S_SCAN_CHK;
         end

         S_SCAN_CHK: begin
            if (rd_data == CH_SPACE) begin
               limit_in = idx_inc;
               move_in  = 1'b1;
               idx_in   = '0;
               state_in = S_EMIT_RD;
            end else if (idx_ff == '0) begin
               limit_in = column_ff;
               move_in  = 1'b0;
               idx_in   = '0;
               state_in = S_EMIT_RD;
            end else begin
               state_in = S_SCAN_RD;
            end
         end

         // Emit the held bytes below the limit, one per read.
         S_EMIT_RD: begin
            store_req.rd_en   = 1'b1;
            store_req.rd_addr = idx_ff[IDX_W-1:0];
            state_in          = S_EMIT_OUT;
         end

         S_EMIT_OUT: begin
            if (out_free) begin
               emit.valid = 1'b1;
               emit.data  = rd_data;
               if (idx_at_limit) begin
                  state_in = S_CR;
               end else begin
                  idx_in   = idx_inc;
                  state_in = S_EMIT_RD;
               end
            end
         end

         S_CR: begin
            if (out_free) begin
               emit.valid = 1'b1;
               emit.data  = CH_CR;
               state_in   = S_LF;
            end
         end

         // The line feed closes the run unless a hard-mode byte follows.
         S_LF: begin
            if (out_free) begin
               emit.valid = 1'b1;
               emit.data  = CH_LF;
               emit.last  = !hard_ff;
               if (move_ff && limit_ff != column_ff) begin
                  idx_in   = limit_ff;
                  state_in = S_MOVE_RD;
               end else begin
                  column_in = '0;
                  state_in  = wr_ff ? S_WRITE : S_IDLE;
               end
            end
         end

         // Shift the bytes after the space down to the start of the store.
         S_MOVE_RD: begin
            store_req.rd_en   = 1'b1;
            store_req.rd_addr = idx_ff[IDX_W-1:0];
            state_in          = S_MOVE_WR;
         end

         S_MOVE_WR: begin
            store_req.wr_en   = 1'b1;
            store_req.wr_addr = idx_off[IDX_W-1:0];
            store_req.wr_data = rd_data;
            if (idx_at_column) begin
               column_in = column_ff - limit_ff;
               state_in  = S_WRITE;
            end else begin
               idx_in   = idx_inc;
               state_in = S_MOVE_RD;
            end
         end

         // Append the new byte while the store has room.
         S_WRITE: begin
            if (column_ff < col_type'(LINE_DEPTH)) begin
               store_req.wr_en   = 1'b1;
               store_req.wr_addr = column_ff[IDX_W-1:0];
               store_req.wr_data = char_ff;
               column_in         = column_ff + col_type'(1);
            end
            state_in = hard_ff ? S_CHAR : S_IDLE;
         end

         S_CHAR: begin
            if (out_free) begin
               emit.valid = 1'b1;
               emit.data  = char_ff;
               emit.last  = 1'b1;
               state_in   = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         column_ff <= '0;
      end else begin
         state_ff  <= state_in;
         column_ff <= column_in;
      end
      idx_ff   <= idx_in;
      limit_ff <= limit_in;
      char_ff  <= char_in;
      move_ff  <= move_in;
      wr_ff    <= wr_in;
      hard_ff  <= hard_in;
   end

   // The column never runs past the end of the store.
   a_column_range: assert property (@(posedge clock) disable iff (reset)
      column_ff <= col_type'(LINE_DEPTH))
      else $error("column beyond line store depth");

   // A word is only produced when the output register can take it.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> out_free)
      else $error("word emitted into a full output register");

   // Space check always follows its own read.
   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN_CHK |-> $past(state_ff) == S_SCAN_RD)
      else $error("space check without a preceding read");

   // Emit reads stay below the emit limit.
   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT_RD |-> idx_ff < limit_ff)
      else $error("emit index past limit");

endmodule

// ===== sv/text_line_folder.sv =====
// Text line folder: wraps a byte stream to the programmed width with CR LF
// line ends, either breaking hard at the width or, in space mode, at the last
// space of a held line. Each input word causes zero or more output words; the
// last of them carries rsp_tlast. In hard mode a plain byte is accepted,
// written to the store and echoed. In space mode a byte that does not break is
// accepted and written; a break scans, emits and moves bytes one access at a
// time, since every access goes through the single read port of the line
// store, whose read data is registered. An output register separates the
// sequencer from the result channel, and a stall there holds the sequencer.
// The line store needs no clearing after reset: only written entries are read.
module text_line_folder (
   input  logic                           clock,
   input  logic                           reset,
   // Input channel.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] text_byte
   input  logic                           req_tuser,   // [0] command
   // Result channel.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,   // [7:0] out_byte
   output logic                           rsp_tlast,   // run_last
   // Register port.
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [tlf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import tlf_pkg::*;

   logic [5:0]    line_width_ff, line_width_in;
   logic          break_at_space_ff, break_at_space_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_data_ff, rsp_data_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          csr_write;
   logic [0:0]    csr_index;
   logic          out_free;
   emit_type      emit;
   store_req_type store_req;
   logic [7:0]    rd_data;

   // Register writes and read-back.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[2:2];

   always_comb begin
      line_width_in     = line_width_ff;
      break_at_space_in = break_at_space_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_LINE_WIDTH:     line_width_in     = csr_pwdata[5:0];
            REG_BREAK_AT_SPACE: break_at_space_in = csr_pwdata[0];
            default:            line_width_in     = line_width_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_LINE_WIDTH:     csr_prdata = {26'd0, line_width_ff};
         REG_BREAK_AT_SPACE: csr_prdata = {31'd0, break_at_space_ff};
         default:            csr_prdata = '0;
      endcase
   end

   // Output register: loads a new word whenever it is empty or being taken.
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit.data;
         rsp_last_in  = emit.last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff     <= 6'd62;
         break_at_space_ff <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         line_width_ff     <= line_width_in;
         break_at_space_ff <= break_at_space_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   tlf_sequencer u_sequencer (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_command    (req_tuser),
      .req_char       (req_tdata),
      .req_ready      (req_tready),
      .width          (eff_width(line_width_ff)),
      .break_at_space (break_at_space_ff),
      .out_free       (out_free),
      .emit           (emit),
      .store_req      (store_req),
      .rd_data        (rd_data)
   );

   tlf_line_store u_line_store (
      .clock     (clock),
      .store_req (store_req),
      .rd_data   (rd_data)
   );

endmodule

// ===== dv/text_line_folder_tb.sv =====
module text_line_folder_tb;
   import tlf_pkg::*;

   // No accepted word for this many cycles means the block has hung.
   localparam int STALL_LIMIT  = 5000;
   // A break can keep the sequencer busy after its last word has gone out.
   localparam int DRAIN_CYCLES = 2 * 3 * LINE_DEPTH + 16;
   localparam int RANDOM_RUNS  = 4;
   localparam int RUN_WORDS    = 20;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } folded_char_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = 8'h00;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // Predicted state of the folder.
   logic [7:0]      held_line [LINE_DEPTH];
   int              held_count = 0;
   logic [5:0]      wrap_width = 6'd62;
   logic            space_mode = 1'b0;
   folded_char_type run_chars [$];
   folded_char_type expected_chars [$];
   folded_char_type oldest;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatch_count = 0;
   int stall_cycles = 0;

   text_line_folder i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void emit_char(input logic [7:0] c);
      folded_char_type w;
      w.ch   = c;
      w.last = 1'b0;
      run_chars.push_back(w);
   endfunction

   function automatic void emit_held(input int count);
      for (int j = 0; j < count && j < LINE_DEPTH; j++) begin
         emit_char(held_line[j]);
      end
   endfunction

   function automatic void emit_crlf();
      emit_char(CH_CR);
      emit_char(CH_LF);
   endfunction

   function automatic void store_char(input logic [7:0] c);
      if (held_count < LINE_DEPTH) begin
         held_line[held_count] = c;
         held_count++;
      end
   endfunction

   // Works out the words that one accepted input word causes and queues them.
   function automatic void fold_char(input logic cmd, input logic [7:0] c);
      int w;
      int split;
      int rest;
      run_chars.delete();
      w = (wrap_width == 6'd0) ? WIDTH_WHEN_ZERO : int'(wrap_width);
      if (w > LINE_DEPTH) begin
         w = LINE_DEPTH;
      end
      if (held_count > LINE_DEPTH) begin
         held_count = LINE_DEPTH;
      end

      if (cmd == CMD_END) begin
         if (space_mode) begin
            emit_held(held_count);
         end
         if (held_count > 0) begin
            emit_crlf();
         end
         held_count = 0;
      end else if (c == CH_LF) begin
         if (space_mode) begin
            emit_held(held_count);
         end
         emit_crlf();
         held_count = 0;
      end else if (c == CH_CR) begin
         // Carriage returns from the source are discarded.
      end else if (space_mode) begin
         if (held_count >= w) begin
            // Find the last space of the held line.
            split = -1;
            for (int i = held_count - 1; i >= 0; i--) begin
               if (split < 0 && held_line[i] == CH_SPACE) begin
                  split = i;
               end
            end
            if (split >= 0) begin
               rest = held_count - split - 1;
               emit_held(split + 1);
               emit_crlf();
               for (int k = 0; k < rest; k++) begin
                  held_line[k] = held_line[split + 1 + k];
               end
               held_count = rest;
            end else begin
               emit_held(held_count);
               emit_crlf();
               held_count = 0;
            end
         end
         store_char(c);
      end else begin
         if (held_count >= w) begin
            emit_crlf();
            held_count = 0;
         end
         store_char(c);
         emit_char(c);
      end

      if (run_chars.size() > 0) begin
         run_chars[run_chars.size() - 1].last = 1'b1;
      end
      foreach (run_chars[i]) begin
         expected_chars.push_back(run_chars[i]);
      end
   endfunction

   // Sends one word, with a random gap before it, and predicts on acceptance.
   task automatic send_word(input logic cmd, input logic [7:0] c);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
      fold_char(cmd, c);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_word(CMD_TEXT, s[i]);
      end
   endtask

   // Stops sending and waits until the block has gone quiet.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes both registers in back-to-back transfers; the block must be idle.
   task automatic program_folder(input logic [5:0] width, input logic mode);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {REG_LINE_WIDTH, 2'b00};
      csr_pwdata  <= {26'd0, width};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      wrap_width = width;
      csr_penable <= 1'b0;
      csr_paddr   <= {REG_BREAK_AT_SPACE, 2'b00};
      csr_pwdata  <= {31'd0, mode};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      space_mode = mode;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Mostly words and spaces with the odd line end, plus some raw bytes.
   function automatic logic [7:0] pick_char();
      int r;
      r = $urandom_range(99);
      if (r < 55) begin
         return 8'(8'h61 + $urandom_range(25));
      end else if (r < 76) begin
         return CH_SPACE;
      end else if (r < 81) begin
         return CH_LF;
      end else if (r < 85) begin
         return CH_CR;
      end
      return 8'($urandom_range(255));
   endfunction

   // Hard breaks, byte extremes, dropped CR, LF and both kinds of end word.
   task automatic test_hard_wrap();
      settle();
      program_folder(6'd3, 1'b0);
      send_text("ab");
      send_word(CMD_TEXT, 8'h00);
      send_word(CMD_TEXT, 8'hFF);
      send_word(CMD_TEXT, CH_CR);
      send_word(CMD_TEXT, CH_LF);
      send_word(CMD_END, 8'h00);
      send_word(CMD_TEXT, "x");
      send_word(CMD_END, 8'h5A);
   endtask

   // Break at a space, break with no space, LF and end flushing the held line.
   task automatic test_space_wrap();
      settle();
      program_folder(6'd5, 1'b1);
      send_text("a bcdefg\nh");
      send_word(CMD_END, 8'hFF);
   endtask

   // Mode and width changed in the middle of a line, zero width included.
   task automatic test_mode_switch();
      settle();
      program_folder(6'd5, 1'b1);
      send_text("xy");
      settle();
      program_folder(6'd0, 1'b0);
      send_word(CMD_TEXT, "z");
      settle();
      program_folder(6'd2, 1'b1);
      send_word(CMD_TEXT, "q");
      send_word(CMD_END, 8'h00);
   endtask

   // Random text under several settings, both modes and the width extremes.
   task automatic test_random_text(input int phase);
      logic [5:0] width;
      for (int s = 0; s < RANDOM_RUNS; s++) begin
         settle();
         unique case (s)
            0: begin
               width = 6'd1;
            end
            1: begin
               width = 6'd63;
            end
            2: begin
               width = 6'd0;
            end
            default: begin
               width = 6'($urandom_range(12, 2));
            end
         endcase
         program_folder(width, 1'((s + phase) % 2));
         repeat (RUN_WORDS) begin
            if ($urandom_range(99) < 4) begin
               send_word(CMD_END, 8'($urandom_range(255)));
            end else begin
               send_word(CMD_TEXT, pick_char());
            end
         end
      end
   endtask

   // Result checker; the receiver stalls at random.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_chars.size() == 0) begin
            $error("unexpected word: out_byte %h run_last %b", rsp_tdata, rsp_tlast);
            mismatch_count++;
         end else begin
            oldest = expected_chars.pop_front();
            if (rsp_tdata !== oldest.ch) begin
               $error("out_byte: expected %h, got %h", oldest.ch, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tlast !== oldest.last) begin
               $error("run_last: expected %b, got %b", oldest.last, rsp_tlast);
               mismatch_count++;
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog: any accepted word on any port restarts the count.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 9;
      recv_idle_pct = 55;
      test_hard_wrap();
      test_space_wrap();
      test_mode_switch();
      test_random_text(0);

      send_idle_pct = 55;
      recv_idle_pct = 9;
      test_random_text(1);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_text(2);

      settle();
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
